@@ design/matrix_congruence_at_b_a_assert.svh @@
// Assertion macros used by the congruence transform top level.
`ifndef MATRIX_CONGRUENCE_AT_B_A_ASSERT_SVH
`define MATRIX_CONGRUENCE_AT_B_A_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Implication or plain property checked at every clock edge outside reset.
`define MCAB_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// Condition that must never be true outside reset.
`define MCAB_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define MCAB_ASSERT(lbl, clk, rst, prop)
`define MCAB_NEVER(lbl, clk, rst, cond)
`endif
`endif

@@ design/mcab_pkg.sv @@
// Shared types and constants for the congruence transform.
`default_nettype none
package mcab_pkg;
  localparam int SUM_W = 68;
  localparam int ACC_W = 104;

  typedef enum logic [1:0] {
    FORM_GEN  = 2'd0,
    FORM_SYM  = 2'd1,
    FORM_DIAG = 2'd2,
    FORM_RSVD = 2'd3
  } form_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ISSUE,
    ST_WAIT
  } state_t;

  // Element write broadcast to every cell.
  typedef struct packed {
    logic              en;
    logic              kind;
    logic [2:0]        row;
    logic [2:0]        col;
    logic signed [31:0] value;
  } wr_t;

  // Partial sum and tags moving along the chain.
  typedef struct packed {
    logic                    valid;
    logic [2:0]              i;
    logic [2:0]              w;
    logic [2:0]              j;
    logic                    jlast;
    logic                    mend;
    logic signed [SUM_W-1:0] sum;
    logic signed [31:0]      aj;
  } beat_t;

  // Finished result element from the tail.
  typedef struct packed {
    logic               valid;
    logic [2:0]         i;
    logic [2:0]         w;
    logic signed [31:0] result;
    logic               sat;
    logic               mend;
  } res_t;
endpackage
`default_nettype wire

@@ design/mcab_cell.sv @@
// One chain cell: holds row K of A and row and column K of B, adds its term.
`default_nettype none
module mcab_cell #(
  parameter int K      = 0,
  parameter int A_ROWS = 3,
  parameter int A_COLS = 3
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire mcab_pkg::wr_t  wr,
  input  wire logic [1:0]     form,
  input  wire mcab_pkg::beat_t fwd_in,
  output mcab_pkg::beat_t     fwd_out
);
  import mcab_pkg::*;

  localparam int CW = (A_COLS > 1) ? $clog2(A_COLS) : 1;
  localparam int RW = (A_ROWS > 1) ? $clog2(A_ROWS) : 1;

  logic signed [31:0] a_row [0:A_COLS-1];
  logic signed [31:0] b_row [0:A_ROWS-1];
  logic signed [31:0] b_col [0:A_ROWS-1];

  logic signed [31:0] beff;
  logic signed [31:0] a_i;
  beat_t              s1;
  logic signed [63:0] prod;

  // Element stores; an entry is undefined until written.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      if (!wr.kind) begin
        if (wr.row == 3'(K) && {1'b0, wr.col} < 4'(A_COLS)) begin
          a_row[wr.col[CW-1:0]] <= wr.value;
        end
      end else if (form == FORM_DIAG) begin
        if (wr.row == 3'(K)) begin
          b_row[RW'(K)] <= wr.value;
        end
      end else if ({1'b0, wr.row} < 4'(A_ROWS) && {1'b0, wr.col} < 4'(A_ROWS) &&
                   (form != FORM_SYM || wr.row <= wr.col)) begin
        if (wr.row == 3'(K)) begin
          b_row[wr.col[RW-1:0]] <= wr.value;
        end
        if (wr.col == 3'(K)) begin
          b_col[wr.row[RW-1:0]] <= wr.value;
        end
      end
    end
  end

  // Effective B entry (K, j) for the selected form.
  always_comb begin
    a_i = a_row[fwd_in.i[CW-1:0]];
    case (form)
      FORM_DIAG: beff = (fwd_in.j == 3'(K)) ? b_row[RW'(K)] : 32'sd0;
      FORM_SYM:  beff = (3'(K) <= fwd_in.j) ? b_row[fwd_in.j[RW-1:0]]
                                            : b_col[fwd_in.j[RW-1:0]];
      default:   beff = b_row[fwd_in.j[RW-1:0]];
    endcase
  end

  // Multiply stage, then add stage; A(j, w) is picked up by cell j.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid      <= 1'b0;
      fwd_out.valid <= 1'b0;
    end else begin
      s1.valid      <= fwd_in.valid;
      fwd_out.valid <= s1.valid;
    end
    s1.i     <= fwd_in.i;
    s1.w     <= fwd_in.w;
    s1.j     <= fwd_in.j;
    s1.jlast <= fwd_in.jlast;
    s1.mend  <= fwd_in.mend;
    s1.sum   <= fwd_in.sum;
    s1.aj    <= (fwd_in.j == 3'(K)) ? a_row[fwd_in.w[CW-1:0]] : fwd_in.aj;
    prod     <= a_i * beff;
    fwd_out.i     <= s1.i;
    fwd_out.w     <= s1.w;
    fwd_out.j     <= s1.j;
    fwd_out.jlast <= s1.jlast;
    fwd_out.mend  <= s1.mend;
    fwd_out.aj    <= s1.aj;
    fwd_out.sum   <= s1.sum + {{(SUM_W-64){prod[63]}}, prod};
  end
endmodule
`default_nettype wire

@@ design/mcab_tail.sv @@
// Tail of the chain: multiplies by A(j, w), sums over j, rounds and saturates.
`default_nettype none
module mcab_tail (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire mcab_pkg::beat_t fwd_in,
  output mcab_pkg::res_t       res
);
  import mcab_pkg::*;

  beat_t                   sa;
  logic signed [65:0]      lo_p;
  logic signed [66:0]      hi_p;
  beat_t                   sb;
  logic signed [ACC_W-1:0] prod;
  logic                    cv;
  logic [2:0]              ci;
  logic [2:0]              cw;
  logic                    cm;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] rnd;
  logic                    fits;

  // Split product: low 33 bits unsigned, high part signed.
  always_ff @(posedge clk) begin
    if (rst) begin
      sa <= '0;
      sb <= '0;
      cv <= 1'b0;
    end else begin
      sa <= fwd_in;
      sb <= sa;
      cv <= sb.valid && sb.jlast;
    end
    lo_p <= $signed({1'b0, fwd_in.sum[32:0]}) * fwd_in.aj;
    hi_p <= $signed(fwd_in.sum[SUM_W-1:33]) * fwd_in.aj;
    prod <= ({{(ACC_W-67){hi_p[66]}}, hi_p} <<< 33) +
            {{(ACC_W-66){lo_p[65]}}, lo_p};
    if (sb.valid) begin
      acc <= (sb.j == 3'd0) ? prod : acc + prod;
      ci  <= sb.i;
      cw  <= sb.w;
      cm  <= sb.mend;
    end
  end

  // Round half up at bit 31, then clip to 32 signed bits.
  always_comb begin
    rnd  = acc + ACC_W'(64'h8000_0000);
    fits = (rnd[ACC_W-1:63] == '0) || (rnd[ACC_W-1:63] == '1);
    res.valid  = cv;
    res.i      = ci;
    res.w      = cw;
    res.mend   = cm;
    res.sat    = !fits;
    res.result = fits ? rnd[63:32] : (rnd[ACC_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
  end
endmodule
`default_nettype wire

@@ design/matrix_congruence_at_b_a.sv @@
// Top level of the A-transpose times B times A congruence transform.
//
//  channel  dir  handshake          payload
//  s_*      in   tvalid/tready      tdata{value,col,row} tuser kind, tlast last
//  m_*      out  tvalid/tready      tdata{result,out_col,out_row} tuser saturated,
//                                   tlast end_of_matrix
//  apb      in   psel/penable/...   b_form at address 0
//
// Loading accepts an element whenever s_tvalid is high. After the last element
// the sequencer feeds A_ROWS beats per result into a chain of A_ROWS cells
// (a multiply and an add stage each), a three-stage tail and the output
// register; it issues the next result only after the previous one leaves the
// tail, and its first beat waits while the output register holds a result.
// Input is not taken while results are produced. Reset is synchronous.
`default_nettype none
`include "matrix_congruence_at_b_a_assert.svh"
module matrix_congruence_at_b_a #(
  parameter int A_ROWS = 3,
  parameter int A_COLS = 3
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // row[2:0], col[5:3], value[37:6], zero pad
  input  wire logic        s_tuser,   // kind
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // out_row[2:0], out_col[5:3], result[37:6], zero
  output logic             m_tuser,   // saturated
  output logic             m_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import mcab_pkg::*;

  localparam logic [2:0] ILAST = 3'(A_COLS - 1);
  localparam logic [2:0] JLAST = 3'(A_ROWS - 1);

  logic [1:0] b_form;
  state_t     state;
  state_t     state_next;
  logic [2:0] i_cnt;
  logic [2:0] w_cnt;
  logic [2:0] j_cnt;
  logic       issue_go;
  logic       accept;
  wr_t        wr;
  beat_t      chain [0:A_ROWS];
  res_t       res;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {30'd0, b_form} : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) begin
      b_form <= FORM_GEN;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      b_form <= pwdata[1:0];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:  if (s_tvalid && s_tlast) state_next = ST_ISSUE;
      ST_ISSUE: if (issue_go && j_cnt == JLAST) state_next = ST_WAIT;
      ST_WAIT: begin
        if (res.valid) state_next = res.mend ? ST_LOAD : ST_ISSUE;
      end
      default:  state_next = ST_LOAD;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_tready = (state == ST_LOAD);
    issue_go = (state == ST_ISSUE) && (j_cnt != 3'd0 || !m_tvalid);
  end

  assign accept   = s_tvalid && s_tready;
  assign wr.en    = accept;
  assign wr.kind  = s_tuser;
  assign wr.row   = s_tdata[2:0];
  assign wr.col   = s_tdata[5:3];
  assign wr.value = s_tdata[37:6];

  // State and result counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      i_cnt <= 3'd0;
      w_cnt <= 3'd0;
      j_cnt <= 3'd0;
    end else begin
      state <= state_next;
      if (accept && s_tlast) begin
        i_cnt <= 3'd0;
        w_cnt <= 3'd0;
        j_cnt <= 3'd0;
      end
      if (issue_go) begin
        j_cnt <= (j_cnt == JLAST) ? 3'd0 : j_cnt + 3'd1;
      end
      if (state == ST_WAIT && res.valid) begin
        if (w_cnt == ILAST) begin
          w_cnt <= 3'd0;
          i_cnt <= i_cnt + 3'd1;
        end else begin
          w_cnt <= w_cnt + 3'd1;
        end
      end
    end
  end

  // Beat entering the chain.
  always_comb begin
    chain[0].valid = issue_go;
    chain[0].i     = i_cnt;
    chain[0].w     = w_cnt;
    chain[0].j     = j_cnt;
    chain[0].jlast = (j_cnt == JLAST);
    chain[0].mend  = (i_cnt == ILAST) && (w_cnt == ILAST);
    chain[0].sum   = '0;
    chain[0].aj    = '0;
  end

  for (genvar k = 0; k < A_ROWS; k++) begin : g_cell
    mcab_cell #(.K(k), .A_ROWS(A_ROWS), .A_COLS(A_COLS)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .wr      (wr),
      .form    (b_form),
      .fwd_in  (chain[k]),
      .fwd_out (chain[k+1])
    );
  end

  mcab_tail u_tail (
    .clk    (clk),
    .rst    (rst),
    .fwd_in (chain[A_ROWS]),
    .res    (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (res.valid) begin
      m_tdata <= {2'b00, res.result, res.w, res.i};
      m_tuser <= res.sat;
      m_tlast <= res.mend;
    end
  end

  `MCAB_ASSERT(a_res_into_empty, clk, rst, res.valid |-> !m_tvalid)
  `MCAB_ASSERT(a_res_while_wait, clk, rst, res.valid |-> state == ST_WAIT)
  `MCAB_ASSERT(a_issue_first, clk, rst, (issue_go && j_cnt == 3'd0) |-> !m_tvalid)
  `MCAB_NEVER(a_load_busy, clk, rst, s_tready && chain[0].valid)
endmodule
`default_nettype wire
